>>> rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// shared types and constants of the two-level page table engine
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int VA_W      = 32;   // virtual address
    localparam int PA_W      = 44;   // physical / translated address
    localparam int FRAME_W   = 32;   // stored frame number
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;

    // stream packing
    localparam int S_TDATA_W = 80;   // virt_addr, phys_addr, zero pad
    localparam int S_TUSER_W = 3;    // opcode, single_page
    localparam int M_TDATA_W = 48;   // translated_addr, zero pad
    localparam int M_TUSER_W = 3;    // status

    typedef enum logic [OP_W-1:0] {
        OP_MAP       = 2'd0,
        OP_UNMAP     = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_SIZE   = 3'd1,
        ST_BUSY       = 3'd2,
        ST_NO_TABLE   = 3'd3,
        ST_NOT_MAPPED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_FILL,
        S_LEAF,
        S_HOLD
    } ctrl_state_t;

    // directory commands from the controller
    typedef struct packed {
        logic rd;
        logic alloc;
    } dir_cmd_t;

    // directory status towards the controller
    typedef struct packed {
        logic clearing;
        logic pool_empty;
    } dir_stat_t;

    // leaf store commands from the controller
    typedef struct packed {
        logic rd;
        logic wr;
        logic fill;
    } leaf_cmd_t;

endpackage

>>> rtl/tpt_directory.sv
// ----------------------------------------------------------------------------
// tpt_directory
// first-level table memory, post-reset clearing sweep and leaf table pool
// ----------------------------------------------------------------------------
module tpt_directory
    import tpt_pkg::*;
#(
    parameter int LEVEL_BITS  = 10,
    parameter int LEAF_TABLES = 16,
    localparam int TBL_W      = $clog2(LEAF_TABLES + 1),
    localparam int TIDX_W     = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dir_cmd_t              cmd,
    input  logic [LEVEL_BITS-1:0] index,
    output logic [TBL_W-1:0]      entry,
    output logic [TIDX_W-1:0]     free_table,
    output dir_stat_t             stat
);

    localparam int DEPTH = 1 << LEVEL_BITS;

    // 0 means no table, k means leaf table k-1
    logic [TBL_W-1:0]      mem [DEPTH];
    logic [TBL_W-1:0]      rd_data_reg;
    logic [LEVEL_BITS-1:0] clr_cnt_reg;
    logic                  clearing_reg;
    logic [TBL_W-1:0]      next_free_reg;

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.alloc) begin
            mem[index] <= next_free_reg + TBL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            next_free_reg <= '0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + LEVEL_BITS'(1);
                if (&clr_cnt_reg) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cmd.alloc) begin
                next_free_reg <= next_free_reg + TBL_W'(1);
            end
        end
    end

    assign entry           = rd_data_reg;
    assign free_table      = TIDX_W'(next_free_reg);
    assign stat.clearing   = clearing_reg;
    assign stat.pool_empty = (next_free_reg == TBL_W'(LEAF_TABLES));

endmodule

>>> rtl/tpt_leaf_store.sv
// ----------------------------------------------------------------------------
// tpt_leaf_store
// second-level frame memory with the new-table fill sweep
// ----------------------------------------------------------------------------
module tpt_leaf_store
    import tpt_pkg::*;
#(
    parameter int LEVEL_BITS  = 10,
    parameter int LEAF_TABLES = 16,
    localparam int TIDX_W     = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1,
    localparam int AW         = TIDX_W + LEVEL_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  leaf_cmd_t          cmd,
    input  logic [AW-1:0]      addr,
    input  logic [FRAME_W-1:0] wr_data,
    input  logic [FRAME_W-1:0] dummy_frame,
    input  logic [TIDX_W-1:0]  fill_table,
    output logic [FRAME_W-1:0] rd_data,
    output logic               fill_busy
);

    localparam int DEPTH = LEAF_TABLES << LEVEL_BITS;

    logic [FRAME_W-1:0]    mem [DEPTH];
    logic [FRAME_W-1:0]    rd_data_reg;
    logic                  fill_busy_reg;
    logic [LEVEL_BITS-1:0] fill_cnt_reg;
    logic [TIDX_W-1:0]     fill_tbl_reg;

    always_ff @(posedge aclk) begin
        if (fill_busy_reg) begin
            mem[{fill_tbl_reg, fill_cnt_reg}] <= dummy_frame;
        end else if (cmd.wr) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            fill_tbl_reg <= fill_table;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_busy_reg <= 1'b0;
            fill_cnt_reg  <= '0;
        end else if (cmd.fill) begin
            fill_busy_reg <= 1'b1;
            fill_cnt_reg  <= '0;
        end else if (fill_busy_reg) begin
            fill_cnt_reg <= fill_cnt_reg + LEVEL_BITS'(1);
            if (&fill_cnt_reg) begin
                fill_busy_reg <= 1'b0;
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign fill_busy = fill_busy_reg;

endmodule

>>> rtl/tpt_ctrl.sv
// ----------------------------------------------------------------------------
// tpt_ctrl
// request sequencer: directory lookup, table allocation, leaf check and result
// ----------------------------------------------------------------------------
module tpt_ctrl
    import tpt_pkg::*;
#(
    parameter int PAGE_SHIFT_BITS = 12,
    parameter int LEVEL_BITS      = 10,
    parameter int LEAF_TABLES     = 16,
    localparam int TBL_W          = $clog2(LEAF_TABLES + 1),
    localparam int TIDX_W         = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1,
    localparam int LEAF_AW        = TIDX_W + LEVEL_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [FRAME_W-1:0]    cfg_wr_data,
    // request side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  op_t                   s_op,
    input  logic [VA_W-1:0]       s_va,
    input  logic [PA_W-1:0]       s_pa,
    input  logic                  s_single,
    // result side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output status_t               m_status,
    output logic [PA_W-1:0]       m_addr,
    // directory
    output dir_cmd_t              dir_cmd,
    output logic [LEVEL_BITS-1:0] dir_index,
    input  logic [TBL_W-1:0]      dir_entry,
    input  dir_stat_t             dir_stat,
    input  logic [TIDX_W-1:0]     free_table,
    // leaf store
    output leaf_cmd_t             leaf_cmd,
    output logic [LEAF_AW-1:0]    leaf_addr,
    output logic [FRAME_W-1:0]    leaf_wr_data,
    output logic [FRAME_W-1:0]    dummy_frame,
    input  logic [FRAME_W-1:0]    leaf_rd_data,
    input  logic                  fill_busy
);

    localparam int VA_X_W = (PAGE_SHIFT_BITS + 2 * LEVEL_BITS > VA_W)
                          ? PAGE_SHIFT_BITS + 2 * LEVEL_BITS : VA_W;

    ctrl_state_t           state_reg, state_next;
    logic [FRAME_W-1:0]    dummy_frame_reg;

    op_t                   op_reg;
    logic [LEVEL_BITS-1:0] first_reg;
    logic [LEVEL_BITS-1:0] second_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic                  single_reg;
    logic [TIDX_W-1:0]     tbl_reg;

    status_t               res_status_reg;
    logic [PA_W-1:0]       res_addr_reg;

    logic                  m_tvalid_reg;
    status_t               m_status_reg;
    logic [PA_W-1:0]       m_addr_reg;

    logic [VA_X_W-1:0]     va_x;
    logic [LEVEL_BITS-1:0] s_first;
    logic [LEVEL_BITS-1:0] s_second;
    logic                  accept;
    logic                  has_tbl;
    logic [TIDX_W-1:0]     dir_tidx;
    logic                  leaf_empty;
    logic                  need_alloc;
    logic                  fin_valid;
    status_t               fin_status;
    logic [PA_W-1:0]       fin_addr;
    logic                  out_free;
    logic                  out_load;

    // index split, upper bits beyond the address read as zero
    assign va_x     = VA_X_W'(s_va);
    assign s_first  = va_x[PAGE_SHIFT_BITS + 2 * LEVEL_BITS - 1 -: LEVEL_BITS];
    assign s_second = va_x[PAGE_SHIFT_BITS + LEVEL_BITS - 1 -: LEVEL_BITS];

    assign has_tbl    = (dir_entry != '0);
    assign dir_tidx   = TIDX_W'(dir_entry - TBL_W'(1));
    assign leaf_empty = (leaf_rd_data == dummy_frame_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = fin_valid && out_free;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_DIR;
            end
            S_DIR: begin
                priority if (fin_valid) state_next = out_free ? S_IDLE : S_HOLD;
                else if (need_alloc)    state_next = S_FILL;
                else                    state_next = S_LEAF;
            end
            S_FILL: begin
                if (!fill_busy) state_next = S_LEAF;
            end
            S_LEAF: begin
                state_next = out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        dir_cmd       = '0;
        dir_index     = first_reg;
        leaf_cmd      = '0;
        leaf_addr     = {tbl_reg, second_reg};
        leaf_wr_data  = dummy_frame_reg;
        need_alloc    = 1'b0;
        fin_valid     = 1'b0;
        fin_status    = ST_OK;
        fin_addr      = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = !dir_stat.clearing;
                dir_index  = s_first;
                dir_cmd.rd = s_tvalid && !dir_stat.clearing;
            end
            S_DIR: begin
                priority if (op_reg == OP_NOP) begin
                    fin_valid = 1'b1;
                end else if (!single_reg && op_reg != OP_TRANSLATE) begin
                    fin_valid  = 1'b1;
                    fin_status = ST_BAD_SIZE;
                end else if (!has_tbl && op_reg == OP_MAP && !dir_stat.pool_empty) begin
                    need_alloc    = 1'b1;
                    dir_cmd.alloc = 1'b1;
                    leaf_cmd.fill = 1'b1;
                end else if (!has_tbl) begin
                    fin_valid  = 1'b1;
                    fin_status = (op_reg == OP_MAP) ? ST_NO_TABLE : ST_NOT_MAPPED;
                end else begin
                    leaf_cmd.rd = 1'b1;
                    leaf_addr   = {dir_tidx, second_reg};
                end
            end
            S_FILL: begin
                leaf_cmd.rd = !fill_busy;
            end
            S_LEAF: begin
                fin_valid = 1'b1;
                unique case (op_reg)
                    OP_MAP: begin
                        if (leaf_empty) begin
                            leaf_cmd.wr  = 1'b1;
                            leaf_wr_data = frame_reg;
                        end else begin
                            fin_status = ST_BUSY;
                        end
                    end
                    OP_UNMAP: begin
                        leaf_cmd.wr = 1'b1;
                        if (leaf_empty) fin_status = ST_NOT_MAPPED;
                    end
                    OP_TRANSLATE: begin
                        if (leaf_empty) begin
                            fin_status = ST_NOT_MAPPED;
                        end else begin
                            fin_addr = PA_W'({{PA_W{1'b0}}, leaf_rd_data} << PAGE_SHIFT_BITS);
                        end
                    end
                    default: fin_status = ST_OK;
                endcase
            end
            S_HOLD: begin
                fin_valid  = 1'b1;
                fin_status = res_status_reg;
                fin_addr   = res_addr_reg;
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            dummy_frame_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                dummy_frame_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_op;
            first_reg  <= s_first;
            second_reg <= s_second;
            frame_reg  <= FRAME_W'(s_pa >> PAGE_SHIFT_BITS);
            single_reg <= s_single;
        end
        if (state_reg == S_DIR) begin
            tbl_reg <= need_alloc ? free_table : dir_tidx;
        end
        if (fin_valid) begin
            res_status_reg <= fin_status;
            res_addr_reg   <= fin_addr;
        end
        if (out_load) begin
            m_status_reg <= fin_status;
            m_addr_reg   <= fin_addr;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_status    = m_status_reg;
    assign m_addr      = m_addr_reg;
    assign dummy_frame = dummy_frame_reg;

endmodule

>>> rtl/two_level_page_table_engine_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top
// two-level translation table with map, unmap and translate requests
// ----------------------------------------------------------------------------
// A virtual address is split into a first-level index and a second-level
// index above the page offset. The first level is a directory memory of
// 2^LEVEL_BITS entries, each naming no table or one of LEAF_TABLES leaf
// tables; the leaf tables share one frame memory. Map takes a leaf table
// from the pool on first use, fills it with the dummy frame and then stores
// the frame; unmap writes the dummy frame back; translate returns the frame
// shifted up by PAGE_SHIFT_BITS. Requests are served one at a time: a
// request that needs no leaf access (no-op, wrong size, missing table) ends
// after the directory read; a leaf check goes through directory read, leaf
// read and, for map and unmap, leaf write; a map that takes a new table
// first waits for the fill sweep of the leaf memory. After reset the
// directory is cleared by a sweep of its 2^LEVEL_BITS entries, during which
// s_tready stays low; cfg writes are taken at any time. A finished result
// sits in an output register, so a new request is taken while it waits.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_top
    import tpt_pkg::*;
#(
    parameter int PAGE_SHIFT_BITS = 12,   // 12 .. 16
    parameter int LEVEL_BITS      = 10,   // 4 .. 10
    parameter int LEAF_TABLES     = 16    // 1 .. 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // dummy frame register
    input  logic                  cfg_wr_en,
    input  logic [FRAME_W-1:0]    cfg_wr_data,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // virt_addr[31:0], phys_addr[75:32], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // opcode[1:0], single_page[2]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // translated_addr[43:0], zero pad
    output logic [M_TUSER_W-1:0]  m_tuser    // status[2:0]
);

    localparam int TBL_W   = $clog2(LEAF_TABLES + 1);
    localparam int TIDX_W  = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1;
    localparam int LEAF_AW = TIDX_W + LEVEL_BITS;

    // unpacked request fields
    op_t                   s_op;
    logic [VA_W-1:0]       s_va;
    logic [PA_W-1:0]       s_pa;
    logic                  s_single;

    // result fields
    status_t               m_status;
    logic [PA_W-1:0]       m_addr;

    // directory link
    dir_cmd_t              dir_cmd;
    dir_stat_t             dir_stat;
    logic [LEVEL_BITS-1:0] dir_index;
    logic [TBL_W-1:0]      dir_entry;
    logic [TIDX_W-1:0]     free_table;

    // leaf store link
    leaf_cmd_t             leaf_cmd;
    logic [LEAF_AW-1:0]    leaf_addr;
    logic [FRAME_W-1:0]    leaf_wr_data;
    logic [FRAME_W-1:0]    leaf_rd_data;
    logic [FRAME_W-1:0]    dummy_frame;
    logic                  fill_busy;

    // stream packing, lowest field first
    assign s_va     = s_tdata[VA_W-1:0];
    assign s_pa     = s_tdata[VA_W + PA_W - 1:VA_W];
    assign s_op     = op_t'(s_tuser[OP_W-1:0]);
    assign s_single = s_tuser[OP_W];

    assign m_tdata  = {{(M_TDATA_W - PA_W){1'b0}}, m_addr};
    assign m_tuser  = m_status;

    // sequencer: owns the handshakes, the dummy frame and the output register
    tpt_ctrl #(
        .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS),
        .LEVEL_BITS      (LEVEL_BITS),
        .LEAF_TABLES     (LEAF_TABLES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_op         (s_op),
        .s_va         (s_va),
        .s_pa         (s_pa),
        .s_single     (s_single),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_status     (m_status),
        .m_addr       (m_addr),
        .dir_cmd      (dir_cmd),
        .dir_index    (dir_index),
        .dir_entry    (dir_entry),
        .dir_stat     (dir_stat),
        .free_table   (free_table),
        .leaf_cmd     (leaf_cmd),
        .leaf_addr    (leaf_addr),
        .leaf_wr_data (leaf_wr_data),
        .dummy_frame  (dummy_frame),
        .leaf_rd_data (leaf_rd_data),
        .fill_busy    (fill_busy)
    );

    // first level: directory memory, clearing sweep, table pool counter
    tpt_directory #(
        .LEVEL_BITS  (LEVEL_BITS),
        .LEAF_TABLES (LEAF_TABLES)
    ) u_directory (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dir_cmd),
        .index      (dir_index),
        .entry      (dir_entry),
        .free_table (free_table),
        .stat       (dir_stat)
    );

    // second level: frame memory, fills a newly taken table with the dummy frame
    tpt_leaf_store #(
        .LEVEL_BITS  (LEVEL_BITS),
        .LEAF_TABLES (LEAF_TABLES)
    ) u_leaf_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (leaf_cmd),
        .addr        (leaf_addr),
        .wr_data     (leaf_wr_data),
        .dummy_frame (dummy_frame),
        .fill_table  (free_table),
        .rd_data     (leaf_rd_data),
        .fill_busy   (fill_busy)
    );

endmodule
